>>> rtl/core/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// bdpc_pkg
// types and constants shared by the button debounce / press classifier
// ----------------------------------------------------------------------------
`default_nettype none

package bdpc_pkg;

    localparam int unsigned STAMP_W  = 32;
    localparam int unsigned THRESH_W = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [THRESH_W-1:0] DEBOUNCE_TIME_RST   = 16'd50;
    localparam logic [THRESH_W-1:0] LONG_PRESS_TIME_RST = 16'd1000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TIME = 2'd1;

    typedef struct packed {
        logic               pin_level;
        logic [STAMP_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic debounced_pressed;
        logic holding;
        logic short_press;
        logic long_press;
    } t_out_item;

    typedef struct packed {
        logic [THRESH_W-1:0] debounce_time;
        logic [THRESH_W-1:0] long_press_time;
    } t_cfg;

endpackage

`default_nettype wire

>>> rtl/core/button_debounce_press_classifier.sv
// ----------------------------------------------------------------------------
// button_debounce_press_classifier
// debounces polls of an active-low button and flags short and long presses
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_ready / i_in_item) takes one pin poll
//   with its millisecond stamp per transfer; the output channel
//   (o_out_valid / i_out_ready / o_out_item) returns exactly one result per
//   poll, in order.
//   the poll sits in an input register, is classified by one pass of
//   subtract-and-compare logic and lands in the result register when that
//   is empty or being drained; throughput one poll per clock while the
//   receiver takes results, as the debounce state updates once per poll.
//   the configuration channel writes one threshold per transfer and is
//   always ready; write only while no poll is in flight.
//   synchronous active-low reset clears the debounce state, empties both
//   registers and loads the threshold defaults (50 ms and 1000 ms).
//   when the receiver stalls the result holds, one more poll is held in the
//   input register, then o_in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_press_classifier (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  bdpc_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output bdpc_pkg::t_out_item                 o_out_item,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [bdpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bdpc_pkg::THRESH_W-1:0]  i_cfg_data
);
    import bdpc_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      w_advance;
    t_cfg      w_cfg;
    t_out_item w_result;

    // poll moves to the result register when that is empty or being drained
    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    bdpc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    bdpc_classify u_classify (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_item   (r_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (w_advance) begin
            r_out_item <= w_result;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/bdpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bdpc_cfg_regs
// threshold registers written over the configuration channel
// ----------------------------------------------------------------------------
`default_nettype none

module bdpc_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [bdpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bdpc_pkg::THRESH_W-1:0]  i_cfg_data,
    output bdpc_pkg::t_cfg                      o_cfg
);
    import bdpc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEBOUNCE_TIME:   n_cfg.debounce_time   = i_cfg_data;
                CFG_LONG_PRESS_TIME: n_cfg.long_press_time = i_cfg_data;
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time   <= DEBOUNCE_TIME_RST;
            r_cfg.long_press_time <= LONG_PRESS_TIME_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/bdpc_classify.sv
// ----------------------------------------------------------------------------
// bdpc_classify
// debounce state and press classification for one poll per step
// ----------------------------------------------------------------------------
`default_nettype none

module bdpc_classify (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  bdpc_pkg::t_in_item i_item,
    input  bdpc_pkg::t_cfg     i_cfg,
    output bdpc_pkg::t_out_item o_result
);
    import bdpc_pkg::*;

    logic               r_stable_level;
    logic               r_hold_active;
    logic               r_long_done;
    logic [STAMP_W-1:0] r_last_stamp;
    logic [STAMP_W-1:0] r_press_stamp;

    logic               n_stable_level;
    logic               n_hold_active;
    logic               n_long_done;
    logic [STAMP_W-1:0] n_last_stamp;
    logic [STAMP_W-1:0] n_press_stamp;

    logic               w_raw;
    logic [STAMP_W-1:0] w_since_stable;
    logic [STAMP_W-1:0] w_since_press;
    logic               w_short;
    logic               w_long;

    // pin is active low
    assign w_raw          = ~i_item.pin_level;
    assign w_since_stable = i_item.now_ms - r_last_stamp;

    always_comb begin
        n_stable_level = r_stable_level;
        n_hold_active  = r_hold_active;
        n_long_done    = r_long_done;
        n_last_stamp   = r_last_stamp;
        n_press_stamp  = r_press_stamp;
        w_short        = 1'b0;
        w_long         = 1'b0;

        if (w_raw == r_stable_level) begin
            n_last_stamp = i_item.now_ms;
        end else if (w_since_stable >= {{(STAMP_W-THRESH_W){1'b0}}, i_cfg.debounce_time}) begin
            n_stable_level = w_raw;
            if (w_raw) begin
                n_hold_active = 1'b1;
                n_press_stamp = i_item.now_ms;
            end else begin
                n_hold_active = 1'b0;
                w_short       = ~r_long_done;
                n_long_done   = 1'b0;
            end
        end

        // press stamp may be taken on this very poll, then the hold time is zero
        w_since_press = i_item.now_ms - n_press_stamp;

        if (n_hold_active && !n_long_done &&
            (w_since_press >= {{(STAMP_W-THRESH_W){1'b0}}, i_cfg.long_press_time})) begin
            w_long      = 1'b1;
            n_long_done = 1'b1;
        end
    end

    assign o_result.debounced_pressed = n_stable_level;
    assign o_result.holding           = n_hold_active;
    assign o_result.short_press       = w_short;
    assign o_result.long_press        = w_long;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_level <= 1'b0;
            r_hold_active  <= 1'b0;
            r_long_done    <= 1'b0;
            r_last_stamp   <= '0;
            r_press_stamp  <= '0;
        end else if (i_step) begin
            r_stable_level <= n_stable_level;
            r_hold_active  <= n_hold_active;
            r_long_done    <= n_long_done;
            r_last_stamp   <= n_last_stamp;
            r_press_stamp  <= n_press_stamp;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/bdpc_checker.sv
// ----------------------------------------------------------------------------
// bdpc_checker
// port-level checks on the press classifier results
// ----------------------------------------------------------------------------
`default_nettype none

module bdpc_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input bdpc_pkg::t_out_item o_out_item
);
    import bdpc_pkg::*;

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // hold timing runs exactly while the press is accepted
    a_hold_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.holding == o_out_item.debounced_pressed))
        else $error("holding differs from debounced level");

    // a short press only on a release
    a_short_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.short_press |-> !o_out_item.debounced_pressed)
        else $error("short press while still pressed");

    // a long press only while held, never with a short press
    a_long_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.long_press |->
            o_out_item.holding && !o_out_item.short_press)
        else $error("long press outside a hold");

endmodule

bind button_debounce_press_classifier bdpc_checker u_bdpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the button debounce / press classifier
// ----------------------------------------------------------------------------
// a directed run walks through the debounce boundary, short and long presses,
// zero and full-scale thresholds and wrapping or backward timestamps. Random
// press cycles with contact bounce then run under several threshold settings.
// A local model of the debounce state predicts each result. Results are
// compared field by field against the queue of predictions. Both channels
// idle and stall at random, with one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import bdpc_pkg::*;

    localparam int unsigned CLK_PERIOD     = 10;
    localparam int unsigned SETTLE_CYCLES  = 4;    // idle wait after the last result is taken
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned HOLD_OFF_LEN   = 80;
    localparam int unsigned PHASE_POLLS    = 120;

    typedef enum int unsigned {
        SINK_OPEN,
        SINK_COIN,
        SINK_PERIODIC,
        SINK_SPARSE
    } t_sink_mode;

    logic                i_clk;
    logic                i_rst_n;
    logic                in_valid;
    logic                o_in_ready;
    t_in_item            in_item;
    logic                o_out_valid;
    logic                out_ready;
    t_out_item           o_out_item;
    logic                cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [THRESH_W-1:0] cfg_data;

    // predicted debounce state and thresholds
    logic                stable_pressed;
    logic                press_held;
    logic                long_fired;
    logic [STAMP_W-1:0]  last_stable_ms;
    logic [STAMP_W-1:0]  press_start_ms;
    logic [THRESH_W-1:0] thr_debounce;
    logic [THRESH_W-1:0] thr_long;

    t_out_item           expected_press_flags[$];
    logic [STAMP_W-1:0]  clock_ms;
    int unsigned         polls_sent;
    int unsigned         results_checked;
    int unsigned         shorts_seen;
    int unsigned         longs_seen;
    int unsigned         mismatches;
    int unsigned         burst_left;
    int unsigned         hold_off_cnt;
    int unsigned         idle_cycles;
    bit                  sender_gaps_on;

    button_debounce_press_classifier uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic t_out_item classify_poll(input t_in_item poll);
        t_out_item          res;
        logic               raw_pressed;
        logic [STAMP_W-1:0] since_stable;
        logic [STAMP_W-1:0] since_press;
        res = '0;
        raw_pressed = ~poll.pin_level;
        since_stable = poll.now_ms - last_stable_ms;
        if (raw_pressed == stable_pressed) begin
            last_stable_ms = poll.now_ms;
        end else if (since_stable >= {16'h0, thr_debounce}) begin
            // acceptance leaves the stable stamp where it was
            stable_pressed = raw_pressed;
            if (raw_pressed) begin
                press_held = 1'b1;
                press_start_ms = poll.now_ms;
            end else begin
                press_held = 1'b0;
                res.short_press = ~long_fired;
                long_fired = 1'b0;
            end
        end
        since_press = poll.now_ms - press_start_ms;
        if (press_held && !long_fired && since_press >= {16'h0, thr_long}) begin
            res.long_press = 1'b1;
            long_fired = 1'b1;
        end
        res.debounced_pressed = stable_pressed;
        res.holding = press_held;
        return res;
    endfunction

    task automatic send_poll(input logic pin, input logic [STAMP_W-1:0] stamp);
        int unsigned gap;
        t_in_item    poll;
        poll.pin_level = pin;
        poll.now_ms = stamp;
        if (sender_gaps_on && burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left != 0) burst_left--;
        in_valid <= 1'b1;
        in_item <= poll;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_press_flags.push_back(classify_poll(poll));
        polls_sent++;
    endtask

    task automatic poll_at(input logic pin, input int unsigned step_ms);
        clock_ms = clock_ms + step_ms;
        send_poll(pin, clock_ms);
    endtask

    // sender stops and waits for every outstanding result
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_press_flags.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_thresholds(input logic [THRESH_W-1:0] deb,
                                   input logic [THRESH_W-1:0] lng);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DEBOUNCE_TIME;
        cfg_data <= deb;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        thr_debounce = deb;
        cfg_index <= CFG_LONG_PRESS_TIME;
        cfg_data <= lng;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        thr_long = lng;
        cfg_valid <= 1'b0;
    endtask

    // contact bounce, a settled hold, bounce again, then a settled release
    task automatic press_cycle(input int unsigned bounce_step, input int unsigned hold_step);
        int unsigned n;
        n = $urandom_range(0, 4);
        repeat (n) poll_at(1'($urandom_range(0, 1)), $urandom_range(0, bounce_step));
        n = $urandom_range(1, 12);
        repeat (n) poll_at(1'b0, $urandom_range(0, hold_step));
        n = $urandom_range(0, 4);
        repeat (n) poll_at(1'($urandom_range(0, 1)), $urandom_range(0, bounce_step));
        n = $urandom_range(1, 6);
        repeat (n) poll_at(1'b1, $urandom_range(0, hold_step));
    endtask

    task automatic stray_polls(input int unsigned hold_step);
        int unsigned n;
        n = $urandom_range(1, 4);
        repeat (n) begin
            if ($urandom_range(0, 3) == 0) clock_ms = $urandom();
            poll_at(1'($urandom_range(0, 1)), $urandom_range(0, hold_step));
        end
    endtask

    task automatic check_field(input string field, input logic want, input logic got);
        if (want !== got) begin
            $display("%0t mismatch on %s: expected %0b actual %0b", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_press_flags.size() == 0) begin
                $display("%0t unexpected result: expected none actual %b",
                         $time, o_out_item);
                mismatches++;
            end else begin
                want = expected_press_flags.pop_front();
                check_field("debounced_pressed", want.debounced_pressed,
                            o_out_item.debounced_pressed);
                check_field("holding", want.holding, o_out_item.holding);
                check_field("short_press", want.short_press, o_out_item.short_press);
                check_field("long_press", want.long_press, o_out_item.long_press);
                results_checked++;
                if (want.short_press) shorts_seen++;
                if (want.long_press) longs_seen++;
            end
        end
    end

    initial begin : result_sink
        t_sink_mode  mode;
        int unsigned mode_left;
        int unsigned tick;
        mode = SINK_OPEN;
        mode_left = 0;
        tick = 0;
        out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_off_cnt != 0) begin
                hold_off_cnt--;
                out_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = t_sink_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 150);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN:     out_ready <= 1'b1;
                    SINK_COIN:     out_ready <= 1'($urandom_range(0, 1));
                    SINK_PERIODIC: out_ready <= (tick % 5) != 0;
                    default:       out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)
            || (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t no transfer for %0d cycles", $time, idle_cycles);
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // default thresholds: debounce boundary, long press, short press
    task automatic test_default_thresholds();
        poll_at(1'b1, 10);
        poll_at(1'b0, 10);
        poll_at(1'b1, 5);
        poll_at(1'b0, 30);
        poll_at(1'b0, 20);     // exactly the debounce time
        poll_at(1'b0, 999);
        poll_at(1'b0, 1);      // long press threshold reached
        poll_at(1'b1, 100);    // release after long press, no short press
        poll_at(1'b0, 60);
        poll_at(1'b1, 100);    // short press
    endtask

    // zero thresholds: acceptance on first poll, long press on the same poll
    task automatic test_zero_thresholds();
        load_thresholds('0, '0);
        poll_at(1'b0, 1);
        poll_at(1'b0, 0);
        poll_at(1'b1, 0);
        poll_at(1'b1, 3);
    endtask

    // full-scale thresholds with stamps wrapping and going backwards
    task automatic test_extreme_stamps();
        load_thresholds('1, '1);
        clock_ms = 32'hFFFF_FFF0;
        poll_at(1'b1, 0);
        poll_at(1'b0, 15);
        poll_at(1'b0, 65535 - 15);
        poll_at(1'b0, 65535);
        clock_ms = '0;
        poll_at(1'b1, 0);
        poll_at(1'b0, 0);
    endtask

    // output held off while the sender keeps offering, then a full drain
    task automatic test_backpressure();
        sender_gaps_on = 1'b0;
        hold_off_cnt = HOLD_OFF_LEN;
        repeat (24) poll_at(1'($urandom_range(0, 1)), $urandom_range(0, 40000));
        sender_gaps_on = 1'b1;
        wait_drained();
    endtask

    task automatic test_random_phases();
        int unsigned         phase_end;
        int unsigned         bounce_step;
        int unsigned         hold_step;
        logic [THRESH_W-1:0] deb;
        logic [THRESH_W-1:0] lng;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0:       begin deb = DEBOUNCE_TIME_RST; lng = LONG_PRESS_TIME_RST; end
                1:       begin deb = '0; lng = '0; end
                2:       begin deb = '1; lng = '1; end
                3:       begin deb = '0; lng = '1; end
                4:       begin deb = '1; lng = '0; end
                default: begin
                    deb = THRESH_W'($urandom_range(1, 200));
                    lng = THRESH_W'($urandom_range(1, 3000));
                end
            endcase
            load_thresholds(deb, lng);
            bounce_step = deb / 3 + 2;
            hold_step = deb / 2 + lng / 6 + 2;
            phase_end = polls_sent + PHASE_POLLS;
            while (polls_sent < phase_end) begin
                if ($urandom_range(0, 9) == 0) stray_polls(hold_step);
                else press_cycle(bounce_step, hold_step);
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_item <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_DEBOUNCE_TIME;
        cfg_data <= '0;
        stable_pressed = 1'b0;
        press_held = 1'b0;
        long_fired = 1'b0;
        last_stable_ms = '0;
        press_start_ms = '0;
        thr_debounce = DEBOUNCE_TIME_RST;
        thr_long = LONG_PRESS_TIME_RST;
        clock_ms = '0;
        polls_sent = 0;
        results_checked = 0;
        shorts_seen = 0;
        longs_seen = 0;
        mismatches = 0;
        burst_left = 0;
        hold_off_cnt = 0;
        idle_cycles = 0;
        sender_gaps_on = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_thresholds();
        test_zero_thresholds();
        test_extreme_stamps();
        test_backpressure();
        test_random_phases();
        wait_drained();

        $display("polls sent %0d, results checked %0d, mismatches %0d",
                 polls_sent, results_checked, mismatches);
        $display("short presses %0d, long presses %0d over eight threshold settings",
                 shorts_seen, longs_seen);
        if (mismatches == 0 && expected_press_flags.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
